// ----- rtl/core/wcpr_pkg.sv -----
// ----------------------------------------------------------------------------
// wcpr_pkg - shared definitions for the wall centering PI regulator
// Register indexes, reset values, the datapath widths and the constants of the
// divide-by-ten stage.
// ----------------------------------------------------------------------------
package wcpr_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_BASE_SPEED   = 3'd0,
      REG_KP_TENTHS    = 3'd1,
      REG_KI_TENTHS    = 3'd2,
      REG_WINDUP_LIMIT = 3'd3,
      REG_DEADBAND     = 3'd4,
      REG_FRONT_MM     = 3'd5,
      REG_SIDE_MINIMUM = 3'd6
   } wcpr_reg_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // Field widths
   localparam int SENSOR_W = 12;
   localparam int FRONT_W  = 13;
   localparam int BASE_W   = 12;
   localparam int GAIN_W   = 8;
   localparam int INTEG_W  = 9;
   localparam int TERM_W   = 18;
   localparam int SUM_W    = 19;
   localparam int OUT_W    = 15;

   // Register reset values
   localparam logic signed [BASE_W-1:0] BASE_SPEED_RST   = 12'sd600;
   localparam logic [GAIN_W-1:0]        KP_TENTHS_RST    = 8'd35;
   localparam logic [GAIN_W-1:0]        KI_TENTHS_RST    = 8'd3;
   localparam logic [GAIN_W-1:0]        WINDUP_LIMIT_RST = 8'd40;
   localparam logic [GAIN_W-1:0]        DEADBAND_RST     = 8'd5;
   localparam logic [FRONT_W-1:0]       FRONT_MM_RST     = 13'd170;
   localparam logic [SENSOR_W-1:0]      SIDE_MINIMUM_RST = 12'd100;

   // Reciprocal of ten: exact floor for magnitudes below 2**18
   localparam int                  RECIP_W     = 19;
   localparam int                  RECIP_SHIFT = 22;
   localparam logic [RECIP_W-1:0]  RECIP_TEN   = 19'd419431;

endpackage

// ----- rtl/core/wcpr_div10.sv -----
// ----------------------------------------------------------------------------
// wcpr_div10 - signed divide by ten, truncating toward zero
// Takes the magnitude, multiplies by a scaled reciprocal and restores the
// sign. Exact for every magnitude the speed sum can reach.
// ----------------------------------------------------------------------------
module wcpr_div10 (
   input  logic signed [wcpr_pkg::SUM_W-1:0] dividend,
   output logic signed [wcpr_pkg::OUT_W-1:0] quotient
);

   localparam int MAG_W  = wcpr_pkg::SUM_W - 1;
   localparam int PROD_W = MAG_W + wcpr_pkg::RECIP_W;

   logic                           neg;
   logic [wcpr_pkg::SUM_W-1:0]     neg_val;
   logic [MAG_W-1:0]               mag;
   logic [PROD_W-1:0]              prod;
   logic [wcpr_pkg::OUT_W-1:0]     quo_mag;

   // take the magnitude of the sum
   assign neg     = dividend[wcpr_pkg::SUM_W-1];
   assign neg_val = -dividend;
   assign mag     = neg ? neg_val[MAG_W-1:0] : dividend[MAG_W-1:0];

   // floor(mag / 10) through the reciprocal
   assign prod    = PROD_W'(mag) * PROD_W'(wcpr_pkg::RECIP_TEN);
   assign quo_mag = prod[wcpr_pkg::RECIP_SHIFT + wcpr_pkg::OUT_W - 1:wcpr_pkg::RECIP_SHIFT];

   // restore the sign
   assign quotient = neg ? -$signed(quo_mag) : $signed(quo_mag);

endmodule

// ----- rtl/core/wall_centering_pi_regulator_core.sv -----
// ----------------------------------------------------------------------------
// wall_centering_pi_regulator_core - wall centering PI speed regulator
// Turns side proximity and front distance samples into a pair of wheel
// speed commands through a clamped PI term with a deadband.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one sensor word: four side readings and the
//   front distance. A word is taken at a clock edge with req_valid high and
//   req_stall low. The rsp_ channel returns one speed word per sensor word,
//   in order, taken when rsp_valid is high and rsp_stall is low.
//   The csr_ channel writes a register by index; csr_ready is always high.
//   Write registers only while no word is in flight.
//   The datapath is three registers deep: input register, PI term register
//   and result register. One word is accepted per cycle while req_stall is
//   low; the integral is updated as a word leaves the input register, so
//   consecutive words see each other's state. When rsp_stall holds the
//   result register, the stages behind it fill and then req_stall rises;
//   no word is lost or repeated.
//   Reset (synchronous, active high) empties the pipeline, clears the
//   integral and loads the register defaults.
// ----------------------------------------------------------------------------
module wall_centering_pi_regulator_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // sensor words
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [wcpr_pkg::SENSOR_W-1:0]          req_right_side,
   input  logic [wcpr_pkg::SENSOR_W-1:0]          req_right_front,
   input  logic [wcpr_pkg::SENSOR_W-1:0]          req_left_side,
   input  logic [wcpr_pkg::SENSOR_W-1:0]          req_left_front,
   input  logic [wcpr_pkg::FRONT_W-1:0]           req_front_distance,
   // speed words
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [wcpr_pkg::OUT_W-1:0]      rsp_right_speed,
   output logic signed [wcpr_pkg::OUT_W-1:0]      rsp_left_speed,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wcpr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wcpr_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // configuration registers
   logic signed [wcpr_pkg::BASE_W-1:0]   base_ff;
   logic [wcpr_pkg::GAIN_W-1:0]          kp_ff;
   logic [wcpr_pkg::GAIN_W-1:0]          ki_ff;
   logic [wcpr_pkg::GAIN_W-1:0]          windup_ff;
   logic [wcpr_pkg::GAIN_W-1:0]          deadband_ff;
   logic [wcpr_pkg::FRONT_W-1:0]         front_mm_ff;
   logic [wcpr_pkg::SENSOR_W-1:0]        side_min_ff;
   wcpr_pkg::wcpr_reg_type               csr_reg;

   // pipeline registers
   logic                                 s1_valid_ff, s1_valid_in;
   logic [wcpr_pkg::SENSOR_W-1:0]        rs_ff, rf_ff, ls_ff, lf_ff;
   logic [wcpr_pkg::FRONT_W-1:0]         fd_ff;
   logic signed [wcpr_pkg::INTEG_W-1:0]  integ_ff, integ_in;
   logic                                 s2_valid_ff, s2_valid_in;
   logic signed [wcpr_pkg::TERM_W-1:0]   term_ff, term_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [wcpr_pkg::OUT_W-1:0]    right_ff, right_in;
   logic signed [wcpr_pkg::OUT_W-1:0]    left_ff, left_in;

   // flow control
   logic out_free, s2_free, s1_move, req_accept;

   // stage one datapath
   logic [wcpr_pkg::SENSOR_W:0]          r_pair, l_pair;
   logic signed [wcpr_pkg::SENSOR_W:0]   err_raw;
   logic signed [13:0]                   integ_sum;
   logic signed [13:0]                   lim_wide;
   logic signed [wcpr_pkg::SENSOR_W:0]   lim_err;
   logic signed [wcpr_pkg::INTEG_W-1:0]  lim_narrow;
   logic signed [wcpr_pkg::INTEG_W-1:0]  integ_clamp, err_clamp, err_used;
   logic [wcpr_pkg::INTEG_W-1:0]         err_abs;
   logic                                 disable_hit, active;
   logic signed [wcpr_pkg::TERM_W-1:0]   prod_kp, prod_ki;

   // stage two datapath
   logic signed [wcpr_pkg::SUM_W-1:0]    base_ext, base_x10, term_ext, sum_right, sum_left;

   // ------------------------------------------------------------------
   // register writes
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_reg   = wcpr_pkg::wcpr_reg_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= wcpr_pkg::BASE_SPEED_RST;
         kp_ff       <= wcpr_pkg::KP_TENTHS_RST;
         ki_ff       <= wcpr_pkg::KI_TENTHS_RST;
         windup_ff   <= wcpr_pkg::WINDUP_LIMIT_RST;
         deadband_ff <= wcpr_pkg::DEADBAND_RST;
         front_mm_ff <= wcpr_pkg::FRONT_MM_RST;
         side_min_ff <= wcpr_pkg::SIDE_MINIMUM_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg)
            wcpr_pkg::REG_BASE_SPEED:   base_ff     <= $signed(csr_wdata[wcpr_pkg::BASE_W-1:0]);
            wcpr_pkg::REG_KP_TENTHS:    kp_ff       <= csr_wdata[wcpr_pkg::GAIN_W-1:0];
            wcpr_pkg::REG_KI_TENTHS:    ki_ff       <= csr_wdata[wcpr_pkg::GAIN_W-1:0];
            wcpr_pkg::REG_WINDUP_LIMIT: windup_ff   <= csr_wdata[wcpr_pkg::GAIN_W-1:0];
            wcpr_pkg::REG_DEADBAND:     deadband_ff <= csr_wdata[wcpr_pkg::GAIN_W-1:0];
            wcpr_pkg::REG_FRONT_MM:     front_mm_ff <= csr_wdata[wcpr_pkg::FRONT_W-1:0];
            wcpr_pkg::REG_SIDE_MINIMUM: side_min_ff <= csr_wdata[wcpr_pkg::SENSOR_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // flow control: each stage advances when the one ahead frees up
   // ------------------------------------------------------------------
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s2_free      = !s2_valid_ff || out_free;
   assign s1_move      = s1_valid_ff && s2_free;
   assign req_stall    = s1_valid_ff && !s2_free;
   assign req_accept   = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign s2_valid_in  = s1_move || (s2_valid_ff && !out_free);
   assign rsp_valid_in = (s2_valid_ff && out_free) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
      end
   end

   // ------------------------------------------------------------------
   // input register: capture a word whenever the stage is free
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         rs_ff <= req_right_side;
         rf_ff <= req_right_front;
         ls_ff <= req_left_side;
         lf_ff <= req_left_front;
         fd_ff <= req_front_distance;
      end
   end

   // ------------------------------------------------------------------
   // stage one: error, integral, clamps, disable, PI term
   // ------------------------------------------------------------------
   assign r_pair  = {1'b0, rs_ff} + {1'b0, rf_ff};
   assign l_pair  = {1'b0, ls_ff} + {1'b0, lf_ff};
   assign err_raw = $signed({1'b0, r_pair[wcpr_pkg::SENSOR_W:1]})
                  - $signed({1'b0, l_pair[wcpr_pkg::SENSOR_W:1]});

   assign integ_sum  = {{5{integ_ff[wcpr_pkg::INTEG_W-1]}}, integ_ff}
                     + {err_raw[wcpr_pkg::SENSOR_W], err_raw};
   assign lim_wide   = $signed({6'b0, windup_ff});
   assign lim_err    = $signed({5'b0, windup_ff});
   assign lim_narrow = $signed({1'b0, windup_ff});

   // clamp integral and error to plus or minus the windup limit
   always_comb begin
      if (integ_sum > lim_wide) begin
         integ_clamp = lim_narrow;
      end else if (integ_sum < -lim_wide) begin
         integ_clamp = -lim_narrow;
      end else begin
         integ_clamp = integ_sum[wcpr_pkg::INTEG_W-1:0];
      end
      if (err_raw > lim_err) begin
         err_clamp = lim_narrow;
      end else if (err_raw < -lim_err) begin
         err_clamp = -lim_narrow;
      end else begin
         err_clamp = err_raw[wcpr_pkg::INTEG_W-1:0];
      end
   end

   // near obstacle or lost wall: drop error and integral
   assign disable_hit = (fd_ff < front_mm_ff) || (rs_ff < side_min_ff) || (ls_ff < side_min_ff);
   assign err_used    = disable_hit ? '0 : err_clamp;
   assign integ_in    = s1_move ? (disable_hit ? '0 : integ_clamp) : integ_ff;

   // deadband: a zero term leaves base speed on both wheels
   assign err_abs = err_used[wcpr_pkg::INTEG_W-1] ? $unsigned(-err_used) : $unsigned(err_used);
   assign active  = err_abs > {1'b0, deadband_ff};

   assign prod_kp = err_used * $signed({1'b0, kp_ff});
   assign prod_ki = integ_in * $signed({1'b0, ki_ff});
   assign term_in = active ? (prod_kp + prod_ki) : '0;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         term_ff <= term_in;
      end
   end

   // ------------------------------------------------------------------
   // stage two: base in tenths plus or minus the term, back to units
   // ------------------------------------------------------------------
   assign base_ext  = {{(wcpr_pkg::SUM_W - wcpr_pkg::BASE_W){base_ff[wcpr_pkg::BASE_W-1]}}, base_ff};
   assign base_x10  = (base_ext <<< 3) + (base_ext <<< 1);
   assign term_ext  = {term_ff[wcpr_pkg::TERM_W-1], term_ff};
   assign sum_right = base_x10 + term_ext;
   assign sum_left  = base_x10 - term_ext;

   wcpr_div10 u_div_right (
      .dividend (sum_right),
      .quotient (right_in)
   );

   wcpr_div10 u_div_left (
      .dividend (sum_left),
      .quotient (left_in)
   );

   // result register: load when it frees up
   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_free) begin
         right_ff <= right_in;
         left_ff  <= left_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_left_speed  = left_ff;

`ifndef SYNTHESIS
   // a disabled word leaves the integral cleared
   a_disable_clears_integral: assert property (@(posedge clock) disable iff (reset)
      s1_move && disable_hit |=> integ_ff == '0)
      else $error("integral not cleared after disabled word");

   // a zero term yields base speed on both wheels
   a_zero_term_gives_base: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && out_free && term_ff == '0 |=>
         rsp_right_speed == wcpr_pkg::OUT_W'(base_ff) && rsp_left_speed == wcpr_pkg::OUT_W'(base_ff))
      else $error("zero PI term did not give base speed");

   // a held term word keeps its value
   a_term_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(term_ff))
      else $error("PI term changed while held");

   // the integral only moves when a word leaves the input register
   a_integral_quiet: assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(integ_ff))
      else $error("integral changed without a word");
`endif

endmodule

// ----- sim/tb_wall_centering_pi_regulator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wall_centering_pi_regulator_core - testbench for the wall centering core
// Drives sensor words with random gaps in some phases and stalls the speed words at random in some.
// A tracker class keeps its own copy of the registers and the integral,
// predicts the speed word for every accepted sensor word and compares the
// returned words in order. Several register settings are visited, the
// extremes among them, with register writes made only while the core idles.
// ----------------------------------------------------------------------------
module tb_wall_centering_pi_regulator_core;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 11;
   localparam int WORDS_PER_PHASE = 130;
   // index past the register list; writes to it must be dropped
   localparam logic [wcpr_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      logic [wcpr_pkg::SENSOR_W-1:0] right_side;
      logic [wcpr_pkg::SENSOR_W-1:0] right_front;
      logic [wcpr_pkg::SENSOR_W-1:0] left_side;
      logic [wcpr_pkg::SENSOR_W-1:0] left_front;
      logic [wcpr_pkg::FRONT_W-1:0]  front_distance;
   } sensor_word_type;

   typedef struct {
      logic signed [wcpr_pkg::OUT_W-1:0] right_speed;
      logic signed [wcpr_pkg::OUT_W-1:0] left_speed;
   } speed_word_type;

   // Tracks registers and integral, holds the speed words still owed
   class speed_tracker_type;
      int base_speed;
      int kp;
      int ki;
      int windup;
      int deadband;
      int front_mm;
      int side_min;
      int integral;
      int errors;
      speed_word_type owed_speeds[$];

      function new();
         base_speed = wcpr_pkg::BASE_SPEED_RST;
         kp         = wcpr_pkg::KP_TENTHS_RST;
         ki         = wcpr_pkg::KI_TENTHS_RST;
         windup     = wcpr_pkg::WINDUP_LIMIT_RST;
         deadband   = wcpr_pkg::DEADBAND_RST;
         front_mm   = wcpr_pkg::FRONT_MM_RST;
         side_min   = wcpr_pkg::SIDE_MINIMUM_RST;
         integral   = 0;
         errors     = 0;
      endfunction

      function int clamp_sym(int v, int lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function void apply_write(logic [wcpr_pkg::CSR_INDEX_W-1:0] idx,
                                logic [wcpr_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            wcpr_pkg::REG_BASE_SPEED:   base_speed = $signed(data[wcpr_pkg::BASE_W-1:0]);
            wcpr_pkg::REG_KP_TENTHS:    kp = data[wcpr_pkg::GAIN_W-1:0];
            wcpr_pkg::REG_KI_TENTHS:    ki = data[wcpr_pkg::GAIN_W-1:0];
            wcpr_pkg::REG_WINDUP_LIMIT: windup = data[wcpr_pkg::GAIN_W-1:0];
            wcpr_pkg::REG_DEADBAND:     deadband = data[wcpr_pkg::GAIN_W-1:0];
            wcpr_pkg::REG_FRONT_MM:     front_mm = data[wcpr_pkg::FRONT_W-1:0];
            wcpr_pkg::REG_SIDE_MINIMUM: side_min = data[wcpr_pkg::SENSOR_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the integral and queue the speed word this sample earns
      function void note_sample(sensor_word_type s);
         int rs, rf, ls, lf, fd;
         int err, mag, term, right_cmd, left_cmd;
         speed_word_type w;
         rs = s.right_side;
         rf = s.right_front;
         ls = s.left_side;
         lf = s.left_front;
         fd = s.front_distance;
         err = (rs + rf) / 2 - (ls + lf) / 2;
         integral = clamp_sym(integral + err, windup);
         err = clamp_sym(err, windup);
         if (fd < front_mm || rs < side_min || ls < side_min) begin
            err = 0;
            integral = 0;
         end
         right_cmd = base_speed;
         left_cmd = base_speed;
         mag = (err < 0) ? -err : err;
         if (mag > deadband) begin
            term = err * kp + integral * ki;
            right_cmd = (base_speed * 10 + term) / 10;
            left_cmd = (base_speed * 10 - term) / 10;
         end
         w.right_speed = right_cmd[wcpr_pkg::OUT_W-1:0];
         w.left_speed = left_cmd[wcpr_pkg::OUT_W-1:0];
         owed_speeds.push_back(w);
      endfunction

      function void check_speeds(logic signed [wcpr_pkg::OUT_W-1:0] right_speed,
                                 logic signed [wcpr_pkg::OUT_W-1:0] left_speed);
         speed_word_type w;
         if (owed_speeds.size() == 0) begin
            errors++;
            $display("%0t unexpected speed word: expected none, actual right %0d left %0d",
                     $time, right_speed, left_speed);
            return;
         end
         w = owed_speeds.pop_front();
         if (right_speed !== w.right_speed) begin
            errors++;
            $display("%0t right_speed mismatch: expected %0d, actual %0d",
                     $time, w.right_speed, right_speed);
         end
         if (left_speed !== w.left_speed) begin
            errors++;
            $display("%0t left_speed mismatch: expected %0d, actual %0d",
                     $time, w.left_speed, left_speed);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [wcpr_pkg::SENSOR_W-1:0] req_right_side = '0;
   logic [wcpr_pkg::SENSOR_W-1:0] req_right_front = '0;
   logic [wcpr_pkg::SENSOR_W-1:0] req_left_side = '0;
   logic [wcpr_pkg::SENSOR_W-1:0] req_left_front = '0;
   logic [wcpr_pkg::FRONT_W-1:0]  req_front_distance = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [wcpr_pkg::OUT_W-1:0] rsp_right_speed;
   logic signed [wcpr_pkg::OUT_W-1:0] rsp_left_speed;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [wcpr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [wcpr_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   speed_tracker_type sb = new();
   logic stall_on = 1'b0;
   bit gaps_on;
   int stall_run = 0;
   int idle_cycles = 0;

   wall_centering_pi_regulator_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_right_side     (req_right_side),
      .req_right_front    (req_right_front),
      .req_left_side      (req_left_side),
      .req_left_front     (req_left_front),
      .req_front_distance (req_front_distance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_right_speed    (rsp_right_speed),
      .rsp_left_speed     (rsp_left_speed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stall the speed words in random runs, mostly short, a few long
   always @(posedge clock) begin
      int r;
      if (reset || !stall_on) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(0, 2);
         end else if (r < 34) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(10, 40);
         end else begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(0, 4);
         end
      end
   end

   // Check every accepted speed word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_speeds(rsp_right_speed, rsp_left_speed);
   end

   // Watchdog: give up after a long stretch with no word moving anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("wall_centering_pi_regulator_core verification failed");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [wcpr_pkg::CSR_INDEX_W-1:0] idx, input int value);
      logic [wcpr_pkg::CSR_DATA_W-1:0] data;
      // junk in the bits above the register width must be dropped
      data = wcpr_pkg::CSR_DATA_W'($urandom);
      case (idx)
         wcpr_pkg::REG_BASE_SPEED:
            data[wcpr_pkg::BASE_W-1:0] = value[wcpr_pkg::BASE_W-1:0];
         wcpr_pkg::REG_FRONT_MM:
            data[wcpr_pkg::FRONT_W-1:0] = value[wcpr_pkg::FRONT_W-1:0];
         wcpr_pkg::REG_SIDE_MINIMUM:
            data[wcpr_pkg::SENSOR_W-1:0] = value[wcpr_pkg::SENSOR_W-1:0];
         REG_UNMAPPED: ;
         default:
            data[wcpr_pkg::GAIN_W-1:0] = value[wcpr_pkg::GAIN_W-1:0];
      endcase
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.apply_write(idx, data);
   endtask

   task automatic configure(input int base, input int kp, input int ki, input int windup,
                            input int deadband, input int front_mm, input int side_min);
      write_reg(wcpr_pkg::REG_BASE_SPEED, base);
      write_reg(wcpr_pkg::REG_KP_TENTHS, kp);
      write_reg(wcpr_pkg::REG_KI_TENTHS, ki);
      write_reg(wcpr_pkg::REG_WINDUP_LIMIT, windup);
      write_reg(wcpr_pkg::REG_DEADBAND, deadband);
      write_reg(wcpr_pkg::REG_FRONT_MM, front_mm);
      write_reg(wcpr_pkg::REG_SIDE_MINIMUM, side_min);
      csr_valid <= 1'b0;
   endtask

   // Hold off the sender until every owed speed word is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed_speeds.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_sample(input sensor_word_type s);
      int r, n;
      req_valid          <= 1'b1;
      req_right_side     <= s.right_side;
      req_right_front    <= s.right_front;
      req_left_side      <= s.left_side;
      req_left_front     <= s.left_front;
      req_front_distance <= s.front_distance;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(s);
      if (gaps_on) begin
         r = $urandom_range(0, 99);
         n = (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         if (n > 0) begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   endtask

   task automatic send_fields(input int rs, input int rf, input int ls, input int lf,
                              input int fd);
      sensor_word_type s;
      s.right_side = rs[wcpr_pkg::SENSOR_W-1:0];
      s.right_front = rf[wcpr_pkg::SENSOR_W-1:0];
      s.left_side = ls[wcpr_pkg::SENSOR_W-1:0];
      s.left_front = lf[wcpr_pkg::SENSOR_W-1:0];
      s.front_distance = fd[wcpr_pkg::FRONT_W-1:0];
      send_sample(s);
   endtask

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // Mostly balanced walls near the active band, some threshold hits and noise
   task automatic send_random();
      int pick, lo, spread, d, rs, rf, ls, lf, fd;
      pick = $urandom_range(0, 19);
      lo = sb.side_min;
      spread = sb.windup + sb.deadband + 8;
      ls = $urandom_range(lo, 4095);
      lf = $urandom_range(0, 4095);
      d = $urandom_range(0, 2 * spread);
      rs = clip(ls + d - spread, lo, 4095);
      d = $urandom_range(0, 2 * spread);
      rf = clip(lf + d - spread, 0, 4095);
      fd = $urandom_range(sb.front_mm, 8191);
      if (pick >= 17) begin
         rs = $urandom_range(0, 4095);
         rf = $urandom_range(0, 4095);
         ls = $urandom_range(0, 4095);
         lf = $urandom_range(0, 4095);
         fd = $urandom_range(0, 8191);
      end else if (pick == 16) begin
         case ($urandom_range(0, 2))
            0: if (lo > 0) rs = $urandom_range(0, lo - 1);
            1: if (lo > 0) ls = $urandom_range(0, lo - 1);
            default: if (sb.front_mm > 0) fd = $urandom_range(0, sb.front_mm - 1);
         endcase
      end else if (pick == 15) begin
         fd = sb.front_mm;
         if ($urandom_range(0, 1)) rs = lo;
         else ls = lo;
      end
      send_fields(rs, rf, ls, lf, fd);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         stall_on <= (p % 3 != 1) && (p != 6);
         gaps_on = (p % 3 != 2) && (p != 6);
         case (p)
            0: begin
               write_reg(REG_UNMAPPED, 0);
               csr_valid <= 1'b0;
            end
            1: configure(2047, 255, 255, 255, 0, 0, 0);
            2: configure(-2048, 255, 255, 255, 0, 0, 0);
            3: configure(1100, 200, 200, 0, 0, 0, 0);
            4: configure(-1100, 35, 3, 20, 20, 170, 100);
            5: configure(0, 0, 0, 255, 255, 8191, 4095);
            6: configure(600, 35, 3, 40, 5, 170, 100);
            default: configure($urandom_range(0, 4095) - 2048, $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 40), $urandom_range(0, 600),
                               $urandom_range(0, 400));
         endcase

         if (p == 0) begin
            // field extremes and disable by low sides
            send_fields(0, 0, 0, 0, 0);
            send_fields(4095, 4095, 4095, 4095, 8191);
            send_fields(4095, 4095, 100, 0, 8191);
            send_fields(100, 0, 4095, 4095, 8191);
            // error right at the deadband and one past it, both signs
            send_fields(1005, 1005, 1000, 1000, 500);
            send_fields(1006, 1006, 1000, 1000, 500);
            send_fields(1000, 1000, 1005, 1005, 500);
            send_fields(1000, 1000, 1006, 1006, 500);
            // odd pair sums truncate
            send_fields(1001, 1000, 1000, 1000, 500);
            send_fields(1000, 1000, 1000, 1001, 500);
            // drive the integral into the windup clamp, then the other way
            repeat (3) send_fields(1030, 1030, 1000, 1000, 500);
            repeat (3) send_fields(1000, 1000, 1030, 1030, 500);
            // front just below and at the threshold, sides just below and at
            send_fields(1030, 1030, 1000, 1000, 169);
            send_fields(1030, 1030, 1000, 1000, 170);
            send_fields(99, 2000, 1000, 1000, 500);
            send_fields(1000, 1000, 99, 2000, 500);
            send_fields(100, 2000, 100, 0, 500);
         end

         repeat (WORDS_PER_PHASE) send_random();
         drain();
      end

      repeat (6) @(posedge clock);
      if (sb.errors == 0 && sb.owed_speeds.size() == 0) begin
         $display("wall_centering_pi_regulator_core verification clean");
      end else begin
         $display("wall_centering_pi_regulator_core verification failed");
      end
      $finish;
   end

endmodule
